>>> rtl/kst_pkg.sv
`timescale 1ns / 1ps

package kst_pkg;

   localparam int unsigned ENTRIES_DEFAULT = 16;
   localparam logic [31:0] TTL_RESET       = 32'd120000;
   localparam logic [31:0] PENDING_CAP     = (32'd256 * 32'd1024) + 32'd4;
   localparam logic [31:0] HANDLE_NONE     = 32'hFFFF_FFFF;
   localparam int unsigned CNT_W           = 5;

   typedef enum logic [1:0] {
      CMD_STASH = 2'd0,
      CMD_DROP  = 2'd1,
      CMD_TAKE  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_EXPIRED  = 3'd0,
      KIND_REPLACED = 3'd1,
      KIND_DROPPED  = 3'd2,
      KIND_TAKEN    = 3'd3,
      KIND_DONE     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_STASH,
      OP_DROP,
      OP_TAKE
   } op_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_READ,
      B_EVAL,
      B_WRITE,
      B_DONE
   } back_state_type;

   typedef enum logic [1:0] {
      PASS_SWEEP,
      PASS_TAKE,
      PASS_DROP
   } pass_type;

   typedef struct packed {
      op_type       op;
      logic [63:0]  key_high;
      logic [63:0]  key_middle;
      logic [31:0]  key_low;
      logic [31:0]  addr;
      logic [15:0]  port;
      logic [31:0]  handle;
      logic         enc;
      logic [18:0]  pending;
      logic [31:0]  now;
      logic [4:0]   take_max;
   } request_type;

   typedef struct packed {
      logic [63:0]  key_high;
      logic [63:0]  key_middle;
      logic [31:0]  key_low;
      logic [31:0]  addr;
      logic [15:0]  port;
      logic [31:0]  handle;
      logic         enc;
      logic [18:0]  pending;
      logic [31:0]  stamp;
   } entry_type;

   typedef struct packed {
      kind_type     kind;
      logic [31:0]  handle;
      logic [31:0]  addr;
      logic [15:0]  port;
      logic         enc;
      logic [18:0]  pending;
      logic [CNT_W-1:0] count;
      logic         last;
   } result_type;

endpackage

>>> rtl/kst_front.sv
`timescale 1ns / 1ps

module kst_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [1:0]           cmd,
   input  logic [63:0]          key_high,
   input  logic [63:0]          key_middle,
   input  logic [31:0]          key_low,
   input  logic [31:0]          peer_addr,
   input  logic [15:0]          peer_port,
   input  logic [31:0]          conn_handle,
   input  logic                 enc_active,
   input  logic [31:0]          pending_bytes,
   input  logic [31:0]          now,
   input  logic [4:0]           take_max,
   output logic                 q_valid,
   output kst_pkg::request_type q_req,
   input  logic                 q_take
);

   kst_pkg::request_type q_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   kst_pkg::request_type dec;
   logic                 push_ok, pop_ok;

   // classify the request
   always_comb begin
      dec.key_high   = key_high;
      dec.key_middle = key_middle;
      dec.key_low    = key_low;
      dec.addr       = peer_addr;
      dec.port       = peer_port;
      dec.handle     = conn_handle;
      dec.enc        = enc_active;
      dec.pending    = (pending_bytes > kst_pkg::PENDING_CAP) ?
                       kst_pkg::PENDING_CAP[18:0] : pending_bytes[18:0];
      dec.now        = now;
      dec.take_max   = take_max;
      unique case (kst_pkg::cmd_type'(cmd))
         kst_pkg::CMD_STASH: begin
            dec.op = (conn_handle == kst_pkg::HANDLE_NONE) ?
                     kst_pkg::OP_NONE : kst_pkg::OP_STASH;
         end
         kst_pkg::CMD_DROP: begin
            dec.op = kst_pkg::OP_DROP;
         end
         kst_pkg::CMD_TAKE: begin
            dec.op = (take_max != 5'd0) ? kst_pkg::OP_TAKE : kst_pkg::OP_NONE;
         end
         kst_pkg::CMD_NOP: begin
            dec.op = kst_pkg::OP_NONE;
         end
      endcase
   end

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_req   = q_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign pop_ok  = q_take && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ pop_ok;
      count_in  = count_ff + {1'b0, push_ok} - {1'b0, pop_ok};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

>>> rtl/kst_back.sv
`timescale 1ns / 1ps

module kst_back #(
   parameter int unsigned ENTRIES = kst_pkg::ENTRIES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [31:0]          csr_ttl_ticks,
   input  logic                 q_valid,
   input  kst_pkg::request_type q_req,
   output logic                 q_take,
   output logic                 rsp_valid,
   output kst_pkg::result_type  rsp,
   input  logic                 rsp_pop
);

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   kst_pkg::back_state_type st_ff, st_in;
   kst_pkg::pass_type       pass_ff, pass_in;
   kst_pkg::request_type    req_ff, req_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [kst_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                    match_hit_ff, match_hit_in;
   logic [IDX_W-1:0]        match_idx_ff, match_idx_in;
   logic [31:0]             match_handle_ff, match_handle_in;
   logic                    free_hit_ff, free_hit_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic                    old_any_ff, old_any_in;
   logic [IDX_W-1:0]        old_idx_ff, old_idx_in;
   logic [31:0]             old_age_ff, old_age_in;
   logic [31:0]             old_handle_ff, old_handle_in;
   logic [ENTRIES-1:0]      valid_ff, valid_in;
   logic [31:0]             ttl_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   kst_pkg::result_type     rsp_ff, rsp_in;

   kst_pkg::entry_type      mem_ff [ENTRIES];
   kst_pkg::entry_type      rd_ff;
   logic                    mem_we;
   logic [IDX_W-1:0]        mem_waddr;
   kst_pkg::entry_type      mem_wdata;

   logic                    out_free;
   logic [31:0]             age;
   logic                    v, key_hit, eff_v, want, advance, repl;
   logic [IDX_W-1:0]        slot;
   kst_pkg::result_type     res;

   assign out_free  = !rsp_valid_ff || rsp_pop;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign age       = req_ff.now - rd_ff.stamp;
   assign v         = valid_ff[idx_ff];
   assign key_hit   = v && (rd_ff.key_high == req_ff.key_high) &&
                      (rd_ff.key_middle == req_ff.key_middle) &&
                      (rd_ff.key_low == req_ff.key_low);

   always_comb begin
      st_in           = st_ff;
      pass_in         = pass_ff;
      req_in          = req_ff;
      idx_in          = idx_ff;
      cnt_in          = cnt_ff;
      match_hit_in    = match_hit_ff;
      match_idx_in    = match_idx_ff;
      match_handle_in = match_handle_ff;
      free_hit_in     = free_hit_ff;
      free_idx_in     = free_idx_ff;
      old_any_in      = old_any_ff;
      old_idx_in      = old_idx_ff;
      old_age_in      = old_age_ff;
      old_handle_in   = old_handle_ff;
      valid_in        = valid_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_pop;
      rsp_in          = rsp_ff;
      q_take          = 1'b0;
      mem_we          = 1'b0;
      mem_waddr       = idx_ff;
      mem_wdata       = '{key_high: req_ff.key_high, key_middle: req_ff.key_middle,
                          key_low: req_ff.key_low, addr: req_ff.addr,
                          port: req_ff.port, handle: req_ff.handle,
                          enc: req_ff.enc, pending: req_ff.pending,
                          stamp: req_ff.now};
      eff_v           = v;
      want            = 1'b0;
      advance         = 1'b1;
      repl            = match_hit_ff || !free_hit_ff;
      slot            = match_hit_ff ? match_idx_ff :
                        (free_hit_ff ? free_idx_ff : old_idx_ff);
      res             = '0;
      res.kind        = kst_pkg::KIND_DONE;

      unique case (st_ff)
         kst_pkg::B_IDLE: begin
            if (q_valid) begin
               q_take       = 1'b1;
               req_in       = q_req;
               idx_in       = '0;
               cnt_in       = '0;
               match_hit_in = 1'b0;
               free_hit_in  = 1'b0;
               old_any_in   = 1'b0;
               pass_in      = (q_req.op == kst_pkg::OP_DROP) ?
                              kst_pkg::PASS_DROP : kst_pkg::PASS_SWEEP;
               st_in        = (q_req.op == kst_pkg::OP_NONE) ?
                              kst_pkg::B_DONE : kst_pkg::B_READ;
            end
         end
         kst_pkg::B_READ: begin
            st_in = kst_pkg::B_EVAL;
         end
         kst_pkg::B_EVAL: begin
            unique case (pass_ff)
               kst_pkg::PASS_SWEEP: begin
                  want     = v && (age >= ttl_ff);
                  eff_v    = v && !want;
                  res.kind = kst_pkg::KIND_EXPIRED;
               end
               kst_pkg::PASS_TAKE: begin
                  want     = key_hit && (cnt_ff < req_ff.take_max);
                  res.kind = kst_pkg::KIND_TAKEN;
                  res.addr    = rd_ff.addr;
                  res.port    = rd_ff.port;
                  res.enc     = rd_ff.enc;
                  res.pending = rd_ff.pending;
               end
               kst_pkg::PASS_DROP: begin
                  want     = key_hit;
                  res.kind = kst_pkg::KIND_DROPPED;
               end
               default: begin
                  want = 1'b0;
               end
            endcase
            res.handle = rd_ff.handle;
            if (want && !out_free) begin
               advance = 1'b0;
            end
            if (advance) begin
               if (want) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in           = res;
                  valid_in[idx_ff] = 1'b0;
                  if (pass_ff != kst_pkg::PASS_SWEEP) begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               if (pass_ff == kst_pkg::PASS_SWEEP) begin
                  if (eff_v && key_hit && (rd_ff.addr == req_ff.addr) &&
                      (rd_ff.port == req_ff.port) && !match_hit_ff) begin
                     match_hit_in    = 1'b1;
                     match_idx_in    = idx_ff;
                     match_handle_in = rd_ff.handle;
                  end
                  if (!eff_v && !free_hit_ff) begin
                     free_hit_in = 1'b1;
                     free_idx_in = idx_ff;
                  end
                  if (eff_v && (!old_any_ff || (age >= old_age_ff))) begin
                     old_any_in    = 1'b1;
                     old_idx_in    = idx_ff;
                     old_age_in    = age;
                     old_handle_in = rd_ff.handle;
                  end
               end
               if (idx_ff == LAST_IDX) begin
                  idx_in = '0;
                  priority if (pass_ff == kst_pkg::PASS_SWEEP &&
                               req_ff.op == kst_pkg::OP_STASH) begin
                     st_in = kst_pkg::B_WRITE;
                  end else if (pass_ff == kst_pkg::PASS_SWEEP) begin
                     pass_in = kst_pkg::PASS_TAKE;
                     st_in   = kst_pkg::B_READ;
                  end else begin
                     st_in = kst_pkg::B_DONE;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
                  st_in  = kst_pkg::B_READ;
               end
            end
         end
         kst_pkg::B_WRITE: begin
            if (!repl || out_free) begin
               if (repl) begin
                  res.kind     = kst_pkg::KIND_REPLACED;
                  res.handle   = match_hit_ff ? match_handle_ff : old_handle_ff;
                  rsp_valid_in = 1'b1;
                  rsp_in       = res;
               end
               mem_we         = 1'b1;
               mem_waddr      = slot;
               valid_in[slot] = 1'b1;
               st_in          = kst_pkg::B_DONE;
            end
         end
         kst_pkg::B_DONE: begin
            if (out_free) begin
               res.kind     = kst_pkg::KIND_DONE;
               res.count    = cnt_ff;
               res.last     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = res;
               st_in        = kst_pkg::B_IDLE;
            end
         end
         default: begin
            st_in = kst_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= kst_pkg::B_IDLE;
         pass_ff      <= kst_pkg::PASS_SWEEP;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         match_hit_ff <= 1'b0;
         free_hit_ff  <= 1'b0;
         old_any_ff   <= 1'b0;
         valid_ff     <= '0;
         ttl_ff       <= kst_pkg::TTL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         pass_ff      <= pass_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         match_hit_ff <= match_hit_in;
         free_hit_ff  <= free_hit_in;
         old_any_ff   <= old_any_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            ttl_ff <= csr_ttl_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      match_idx_ff    <= match_idx_in;
      match_handle_ff <= match_handle_in;
      free_idx_ff     <= free_idx_in;
      old_idx_ff      <= old_idx_in;
      old_age_ff      <= old_age_in;
      old_handle_ff   <= old_handle_in;
      rsp_ff          <= rsp_in;
   end

   // record store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem_ff[idx_ff];
   end

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> st_ff == kst_pkg::B_IDLE)
      else $error("sequencer not idle after reset");

   a_take_bound: assert property (@(posedge clock) disable iff (reset)
      (st_ff != kst_pkg::B_IDLE && req_ff.op == kst_pkg::OP_TAKE)
      |-> cnt_ff <= req_ff.take_max)
      else $error("take returned more than take_max");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.kind == kst_pkg::KIND_DONE) == rsp_ff.last))
      else $error("last flag disagrees with done");

   a_oldest_valid: assert property (@(posedge clock) disable iff (reset)
      (st_ff == kst_pkg::B_WRITE && !match_hit_ff && !free_hit_ff)
      |-> (old_any_ff && valid_ff[old_idx_ff]))
      else $error("oldest victim not a live record");

endmodule

>>> rtl/keyed_stash_table_ttl.sv
`timescale 1ns / 1ps

// sequence: stash sweeps every entry and then writes, drop makes one drop pass, take
// sweeps and then makes a take pass, others go straight to done; each also waits while
// an unpopped result sits in the result register; requests are handled one at a time;
// the record store is read once per entry per pass (address, then registered data)
// reset: valid bits cleared at once, ttl back to 120000, queues empty
module keyed_stash_table_ttl #(
   parameter int unsigned ENTRIES = kst_pkg::ENTRIES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [31:0]  csr_ttl_ticks,
   input  logic         req_push,
   output logic         req_full,
   input  logic [1:0]   req_cmd,
   input  logic [63:0]  req_key_high,
   input  logic [63:0]  req_key_middle,
   input  logic [31:0]  req_key_low,
   input  logic [31:0]  req_peer_addr,
   input  logic [15:0]  req_peer_port,
   input  logic [31:0]  req_conn_handle,
   input  logic         req_enc_active,
   input  logic [31:0]  req_pending_bytes,
   input  logic [31:0]  req_now,
   input  logic [4:0]   req_take_max,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [2:0]   rsp_kind,
   output logic [31:0]  rsp_out_handle,
   output logic [31:0]  rsp_out_addr,
   output logic [15:0]  rsp_out_port,
   output logic         rsp_out_enc,
   output logic [18:0]  rsp_out_pending,
   output logic [4:0]   rsp_count,
   output logic         rsp_last
);

   logic                 q_valid;
   kst_pkg::request_type q_req;
   logic                 q_take;
   logic                 rsp_valid;
   kst_pkg::result_type  rsp;

   kst_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push),
      .full          (req_full),
      .cmd           (req_cmd),
      .key_high      (req_key_high),
      .key_middle    (req_key_middle),
      .key_low       (req_key_low),
      .peer_addr     (req_peer_addr),
      .peer_port     (req_peer_port),
      .conn_handle   (req_conn_handle),
      .enc_active    (req_enc_active),
      .pending_bytes (req_pending_bytes),
      .now           (req_now),
      .take_max      (req_take_max),
      .q_valid       (q_valid),
      .q_req         (q_req),
      .q_take        (q_take)
   );

   kst_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_ttl_ticks (csr_ttl_ticks),
      .q_valid       (q_valid),
      .q_req         (q_req),
      .q_take        (q_take),
      .rsp_valid     (rsp_valid),
      .rsp           (rsp),
      .rsp_pop       (rsp_pop)
   );

   assign rsp_empty       = !rsp_valid;
   assign rsp_kind        = rsp.kind;
   assign rsp_out_handle  = rsp.handle;
   assign rsp_out_addr    = rsp.addr;
   assign rsp_out_port    = rsp.port;
   assign rsp_out_enc     = rsp.enc;
   assign rsp_out_pending = rsp.pending;
   assign rsp_count       = rsp.count;
   assign rsp_last        = rsp.last;

endmodule
